/* hdl/lhb_pkg.sv */
// shared types, constants and control structs of the heartbeat blinker
package lhb_pkg;

	localparam int COUNTER_WIDTH  = 32;
	localparam int LOAD_FRAC_BITS = 8;
	localparam int IN_W           = 32;
	localparam int LOAD_W         = LOAD_FRAC_BITS + 7;
	localparam int DIV_W          = (COUNTER_WIDTH > IN_W) ? COUNTER_WIDTH : IN_W;
	localparam int LOAD_OUT_W     = 15;
	localparam int MS_W           = 11;
	localparam int PHASE_W        = 3;
	localparam int STEP_W         = $clog2(LOAD_W);
	localparam int CFG_DATA_W     = 7;
	localparam int CFG_IDX_W      = 3;
	localparam int DIGIT_W        = 9;
	localparam int RECIP_PROD_W   = 16;

	typedef logic [COUNTER_WIDTH-1:0]  cnt_t;
	typedef logic [IN_W-1:0]           in_word_t;
	typedef logic [DIV_W-1:0]          divw_t;
	typedef logic [DIV_W:0]            divx_t;
	typedef logic [DIV_W+LOAD_W-1:0]   prod_t;
	typedef logic [LOAD_W-1:0]         load_t;
	typedef logic [LOAD_W:0]           load_sum_t;
	typedef logic [LOAD_W+1:0]         x3_t;
	typedef logic [LOAD_OUT_W-1:0]     load_out_t;
	typedef logic [MS_W-1:0]           ms_t;
	typedef logic [PHASE_W-1:0]        phase_t;
	typedef logic [STEP_W-1:0]         step_t;
	typedef logic [CFG_DATA_W-1:0]     cfg_data_t;
	typedef logic [CFG_IDX_W-1:0]      cfg_idx_t;
	typedef logic [DIGIT_W-1:0]        digit_t;
	typedef logic [RECIP_PROD_W-1:0]   recip_prod_t;
	typedef logic [1:0]                mode_t;
	typedef logic [6:0]                limit_t;
	typedef logic [2:0]                mask_t;

	localparam load_t FULL_SCALE = load_t'(100) << LOAD_FRAC_BITS;

	localparam ms_t ON_BASE   = ms_t'(100);
	localparam ms_t GAP_BASE  = ms_t'(200);
	localparam ms_t REST_BASE = ms_t'(1600);
	localparam ms_t WAIT_LEN  = ms_t'(1000);

	localparam x3_t ON_ROUND   = x3_t'((10 << LOAD_FRAC_BITS) - 1);
	localparam x3_t GAP_ROUND  = x3_t'((1 << (LOAD_FRAC_BITS + 1)) - 1);
	localparam x3_t REST_ROUND = x3_t'((1 << (LOAD_FRAC_BITS - 2)) - 1);

	localparam recip_prod_t RECIP_TEN   = recip_prod_t'(205);
	localparam int          RECIP_SHIFT = 11;

	localparam phase_t PH_WAIT  = 3'd0;
	localparam phase_t PH_BEAT1 = 3'd1;
	localparam phase_t PH_GAP   = 3'd2;
	localparam phase_t PH_BEAT2 = 3'd3;
	localparam phase_t PH_REST  = 3'd4;

	localparam mode_t MODE_MEAN = 2'd0;
	localparam mode_t MODE_CPU  = 2'd1;
	localparam mode_t MODE_RAM  = 2'd2;

	localparam logic OP_TICK   = 1'b0;
	localparam logic OP_SAMPLE = 1'b1;

	localparam cfg_idx_t REG_LOAD_MODE    = 3'd0;
	localparam cfg_idx_t REG_ACTIVE_LIMIT = 3'd1;
	localparam cfg_idx_t REG_LED_MASK     = 3'd2;
	localparam cfg_idx_t REG_BEEP_ENABLE  = 3'd3;
	localparam cfg_idx_t REG_DTR_ENABLE   = 3'd4;

	typedef struct packed {
		logic accept;
		logic mul_cpu;
		logic mul_ram;
		logic div_step;
		logic wr_cpu;
		logic wr_ram;
		logic tick_len;
		logic out_load;
	} cmd_t;

	typedef struct packed {
		logic out_busy;
	} sts_t;

endpackage

/* hdl/lhb_ctrl.sv */
// controller state machine sequencing samples, ticks and result delivery
module lhb_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	input  logic           operation,
	input  lhb_pkg::sts_t  sts,
	output lhb_pkg::cmd_t  cmd,
	output logic           in_stall
);

	typedef enum logic [7:0] {
		ST_IDLE    = 8'b0000_0001,
		ST_CPU_MUL = 8'b0000_0010,
		ST_CPU_DIV = 8'b0000_0100,
		ST_RAM_MUL = 8'b0000_1000,
		ST_RAM_DIV = 8'b0001_0000,
		ST_RAM_WR  = 8'b0010_0000,
		ST_TICK    = 8'b0100_0000,
		ST_DONE    = 8'b1000_0000
	} state_t;

	state_t          state_q, state_d;
	lhb_pkg::step_t  step_q, step_d;
	logic            step_last;

	assign step_last = (step_q == lhb_pkg::step_t'(lhb_pkg::LOAD_W - 1));
	assign in_stall  = (state_q != ST_IDLE);

	always_comb begin
		state_d = state_q;
		step_d  = step_q;
		cmd     = '0;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.accept = 1'b1;
					state_d = (operation == lhb_pkg::OP_SAMPLE) ? ST_CPU_MUL : ST_TICK;
				end
			end
			ST_CPU_MUL: begin
				cmd.mul_cpu = 1'b1;
				step_d = '0;
				state_d = ST_CPU_DIV;
			end
			ST_CPU_DIV: begin
				cmd.div_step = 1'b1;
				step_d = step_q + lhb_pkg::step_t'(1);
				if (step_last) begin
					state_d = ST_RAM_MUL;
				end
			end
			ST_RAM_MUL: begin
				cmd.mul_ram = 1'b1;
				cmd.wr_cpu = 1'b1;
				step_d = '0;
				state_d = ST_RAM_DIV;
			end
			ST_RAM_DIV: begin
				cmd.div_step = 1'b1;
				step_d = step_q + lhb_pkg::step_t'(1);
				if (step_last) begin
					state_d = ST_RAM_WR;
				end
			end
			ST_RAM_WR: begin
				cmd.wr_ram = 1'b1;
				state_d = ST_DONE;
			end
			ST_TICK: begin
				cmd.tick_len = 1'b1;
				state_d = ST_DONE;
			end
			ST_DONE: begin
				if (!sts.out_busy) begin
					cmd.out_load = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			step_q  <= '0;
		end else begin
			state_q <= state_d;
			step_q  <= step_d;
		end
	end

endmodule

/* hdl/lhb_dp.sv */
// datapath: config registers, load math with serial divider, beat sequencer, output word
module lhb_dp (
	input  logic                       clk,
	input  logic                       arst_n,
	input  lhb_pkg::cmd_t              cmd,
	output lhb_pkg::sts_t              sts,
	input  logic                       cfg_we,
	input  lhb_pkg::cfg_idx_t          cfg_index,
	input  lhb_pkg::cfg_data_t         cfg_data,
	input  logic                       operation,
	input  lhb_pkg::in_word_t          cpu_total_time,
	input  lhb_pkg::in_word_t          cpu_idle_time,
	input  lhb_pkg::in_word_t          mem_available_kb,
	input  lhb_pkg::in_word_t          mem_total_kb,
	input  logic                       out_stall,
	output logic                       out_valid,
	output lhb_pkg::mask_t             led_drive,
	output logic                       dtr_level,
	output logic                       beep_pulse,
	output lhb_pkg::phase_t            phase_now,
	output lhb_pkg::load_out_t         load_q8
);

	lhb_pkg::mode_t     load_mode_q;
	lhb_pkg::limit_t    active_limit_q;
	lhb_pkg::mask_t     led_mask_q;
	logic               beep_enable_q;
	logic               dtr_enable_q;

	lhb_pkg::cnt_t      prev_total_q, prev_idle_q, dt_q, di_q;
	lhb_pkg::in_word_t  avail_q, mtot_q;
	lhb_pkg::load_t     cpu_load_q, ram_load_q, latched_q;
	lhb_pkg::phase_t    phase_q;
	lhb_pkg::ms_t       ms_left_q;
	logic               reload_q, beep_q;

	lhb_pkg::divw_t     rem_q, den_q;
	lhb_pkg::load_t     lo_q, quo_q;

	logic               out_valid_q;

	lhb_pkg::load_t       sel_load;
	lhb_pkg::load_sum_t   load_sum;
	lhb_pkg::load_t       limit_q8;
	lhb_pkg::phase_t      next_phase;
	lhb_pkg::divw_t       mul_num, mul_den;
	lhb_pkg::prod_t       prod;
	lhb_pkg::divx_t       trial, diff;
	logic                 fits;
	lhb_pkg::x3_t         x3;
	lhb_pkg::digit_t      on_digit;
	lhb_pkg::recip_prod_t on_prod;
	lhb_pkg::ms_t         on_len, gap_len, rest_len, new_len;
	logic                 phase_on;

	// load selection
	assign load_sum = lhb_pkg::load_sum_t'(cpu_load_q) + lhb_pkg::load_sum_t'(ram_load_q);

	always_comb begin
		case (load_mode_q)
			lhb_pkg::MODE_CPU: sel_load = cpu_load_q;
			lhb_pkg::MODE_RAM: sel_load = ram_load_q;
			default:           sel_load = lhb_pkg::load_t'(load_sum >> 1);
		endcase
	end

	assign limit_q8 = lhb_pkg::load_t'(active_limit_q) << lhb_pkg::LOAD_FRAC_BITS;

	always_comb begin
		if (phase_q inside {lhb_pkg::PH_BEAT1, lhb_pkg::PH_GAP, lhb_pkg::PH_BEAT2}) begin
			next_phase = phase_q + lhb_pkg::phase_t'(1);
		end else if (sel_load < limit_q8) begin
			next_phase = lhb_pkg::PH_WAIT;
		end else begin
			next_phase = lhb_pkg::PH_BEAT1;
		end
	end

	// scaled multiply feeding the restoring divider
	assign mul_num = cmd.mul_cpu ? lhb_pkg::divw_t'(di_q) : lhb_pkg::divw_t'(avail_q);
	assign mul_den = cmd.mul_cpu ? lhb_pkg::divw_t'(dt_q) : lhb_pkg::divw_t'(mtot_q);
	assign prod    = lhb_pkg::prod_t'(mul_num) * lhb_pkg::prod_t'(lhb_pkg::FULL_SCALE);

	assign trial = {rem_q, lo_q[lhb_pkg::LOAD_W-1]};
	assign diff  = trial - {1'b0, den_q};
	assign fits  = (trial >= {1'b0, den_q});

	// phase lengths in ms from the latched load
	assign x3 = lhb_pkg::x3_t'(latched_q) + (lhb_pkg::x3_t'(latched_q) << 1);
	assign on_digit = lhb_pkg::digit_t'((x3 + lhb_pkg::ON_ROUND) >> lhb_pkg::LOAD_FRAC_BITS);
	assign on_prod  = lhb_pkg::recip_prod_t'(on_digit) * lhb_pkg::RECIP_TEN;
	assign on_len   = lhb_pkg::ON_BASE - lhb_pkg::ms_t'(on_prod >> lhb_pkg::RECIP_SHIFT);
	assign gap_len  = lhb_pkg::GAP_BASE
		- lhb_pkg::ms_t'((x3 + lhb_pkg::GAP_ROUND) >> (lhb_pkg::LOAD_FRAC_BITS + 1));
	assign rest_len = lhb_pkg::REST_BASE
		- lhb_pkg::ms_t'((x3 + lhb_pkg::REST_ROUND) >> (lhb_pkg::LOAD_FRAC_BITS - 2));

	always_comb begin
		case (phase_q)
			lhb_pkg::PH_BEAT1, lhb_pkg::PH_BEAT2: new_len = on_len;
			lhb_pkg::PH_GAP:                      new_len = gap_len;
			lhb_pkg::PH_REST:                     new_len = rest_len;
			default:                              new_len = lhb_pkg::WAIT_LEN;
		endcase
	end

	assign phase_on = (phase_q == lhb_pkg::PH_BEAT1) || (phase_q == lhb_pkg::PH_BEAT2);

	// config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			load_mode_q    <= lhb_pkg::MODE_MEAN;
			active_limit_q <= '0;
			led_mask_q     <= lhb_pkg::mask_t'(1);
			beep_enable_q  <= 1'b0;
			dtr_enable_q   <= 1'b1;
		end else if (cfg_we) begin
			case (cfg_index)
				lhb_pkg::REG_LOAD_MODE:    load_mode_q    <= lhb_pkg::mode_t'(cfg_data);
				lhb_pkg::REG_ACTIVE_LIMIT: active_limit_q <= lhb_pkg::limit_t'(cfg_data);
				lhb_pkg::REG_LED_MASK:     led_mask_q     <= lhb_pkg::mask_t'(cfg_data);
				lhb_pkg::REG_BEEP_ENABLE:  beep_enable_q  <= cfg_data[0];
				lhb_pkg::REG_DTR_ENABLE:   dtr_enable_q   <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// load and sequencer state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_total_q <= '0;
			prev_idle_q  <= '0;
			cpu_load_q   <= '0;
			ram_load_q   <= '0;
			latched_q    <= '0;
			phase_q      <= lhb_pkg::PH_WAIT;
			ms_left_q    <= '0;
			reload_q     <= 1'b0;
			beep_q       <= 1'b0;
		end else begin
			if (cmd.accept) begin
				reload_q <= 1'b0;
				beep_q   <= 1'b0;
				if (operation == lhb_pkg::OP_SAMPLE) begin
					prev_total_q <= lhb_pkg::cnt_t'(cpu_total_time);
					prev_idle_q  <= lhb_pkg::cnt_t'(cpu_idle_time);
				end else if (ms_left_q == '0) begin
					reload_q <= 1'b1;
					phase_q  <= next_phase;
					if (!(phase_q inside {lhb_pkg::PH_BEAT1, lhb_pkg::PH_GAP,
						lhb_pkg::PH_BEAT2})) begin
						latched_q <= sel_load;
					end
					beep_q <= beep_enable_q && ((next_phase == lhb_pkg::PH_BEAT1) ||
						(next_phase == lhb_pkg::PH_BEAT2));
				end
			end
			if (cmd.tick_len) begin
				ms_left_q <= (reload_q ? new_len : ms_left_q) - lhb_pkg::ms_t'(1);
			end
			if (cmd.wr_cpu && (dt_q != '0)) begin
				cpu_load_q <= (di_q >= dt_q) ? '0 : lhb_pkg::FULL_SCALE - quo_q;
			end
			if (cmd.wr_ram && (mtot_q != '0)) begin
				ram_load_q <= (avail_q >= mtot_q) ? '0 : lhb_pkg::FULL_SCALE - quo_q;
			end
		end
	end

	// sample operands and divider
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			dt_q    <= lhb_pkg::cnt_t'(cpu_total_time) - prev_total_q;
			di_q    <= lhb_pkg::cnt_t'(cpu_idle_time) - prev_idle_q;
			avail_q <= mem_available_kb;
			mtot_q  <= mem_total_kb;
		end
		if (cmd.mul_cpu || cmd.mul_ram) begin
			rem_q <= prod[lhb_pkg::DIV_W+lhb_pkg::LOAD_W-1:lhb_pkg::LOAD_W];
			lo_q  <= prod[lhb_pkg::LOAD_W-1:0];
			den_q <= mul_den;
		end else if (cmd.div_step) begin
			rem_q <= fits ? diff[lhb_pkg::DIV_W-1:0] : trial[lhb_pkg::DIV_W-1:0];
			lo_q  <= lo_q << 1;
			quo_q <= {quo_q[lhb_pkg::LOAD_W-2:0], fits};
		end
	end

	// output word register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			led_drive  <= phase_on ? led_mask_q : '0;
			dtr_level  <= phase_on && dtr_enable_q;
			beep_pulse <= beep_q;
			phase_now  <= phase_q;
			load_q8    <= lhb_pkg::load_out_t'(sel_load);
		end
	end

	assign out_valid    = out_valid_q;
	assign sts.out_busy = out_valid_q && out_stall;

endmodule

/* hdl/load_driven_heartbeat_blinker_unit.sv */
// top level of the load-driven heartbeat blinker
// Usage:
// in channel (in_valid / in_stall) carries one word per millisecond tick
// (operation 0) or per load sample (operation 1, counters and memory figures).
// out channel (out_valid / out_stall) returns exactly one word per input word:
// LED lines, DTR level, beep pulse, current phase and the selected Q8 load.
// A sample passes, after acceptance, through a multiply step and one restoring-
// divider step per quotient bit for the CPU load, the same for the RAM load, a
// write step and an output step; a tick passes through a length step and the
// output step. The output step waits while the output register still holds an
// untaken word. The shared serial divider makes a sample's work take longer
// than a tick's.
// One word is in work at a time; in_stall rises after each acceptance and
// falls at the edge that registers the result word.
// The output register holds a finished word while the receiver stalls, and
// the next input word is taken meanwhile; a second result waits until the
// first is taken.
// cfg_we / cfg_index / cfg_data write the mode, limit, mask and enables
// between words. Reset clears loads and sequencer and restores register
// defaults; the first tick after reset starts a new period.
module load_driven_heartbeat_blinker_unit (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  lhb_pkg::cfg_idx_t     cfg_index,
	input  lhb_pkg::cfg_data_t    cfg_data,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic                  operation,
	input  lhb_pkg::in_word_t     cpu_total_time,
	input  lhb_pkg::in_word_t     cpu_idle_time,
	input  lhb_pkg::in_word_t     mem_available_kb,
	input  lhb_pkg::in_word_t     mem_total_kb,
	output logic                  out_valid,
	input  logic                  out_stall,
	output lhb_pkg::mask_t        led_drive,
	output logic                  dtr_level,
	output logic                  beep_pulse,
	output lhb_pkg::phase_t       phase_now,
	output lhb_pkg::load_out_t    load_q8
);

	lhb_pkg::cmd_t cmd;
	lhb_pkg::sts_t sts;

	lhb_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.operation (operation),
		.sts       (sts),
		.cmd       (cmd),
		.in_stall  (in_stall)
	);

	lhb_dp u_dp (
		.clk              (clk),
		.arst_n           (arst_n),
		.cmd              (cmd),
		.sts              (sts),
		.cfg_we           (cfg_we),
		.cfg_index        (cfg_index),
		.cfg_data         (cfg_data),
		.operation        (operation),
		.cpu_total_time   (cpu_total_time),
		.cpu_idle_time    (cpu_idle_time),
		.mem_available_kb (mem_available_kb),
		.mem_total_kb     (mem_total_kb),
		.out_stall        (out_stall),
		.out_valid        (out_valid),
		.led_drive        (led_drive),
		.dtr_level        (dtr_level),
		.beep_pulse       (beep_pulse),
		.phase_now        (phase_now),
		.load_q8          (load_q8)
	);

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("block took a word without going busy");

	a_beep_in_beat: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && beep_pulse |->
			(phase_now == lhb_pkg::PH_BEAT1) || (phase_now == lhb_pkg::PH_BEAT2))
		else $error("beep outside an on phase");

	a_dark_off_beat: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (phase_now != lhb_pkg::PH_BEAT1) && (phase_now != lhb_pkg::PH_BEAT2)
			|-> (led_drive == '0) && !dtr_level)
		else $error("LED or DTR driven outside an on phase");

	a_load_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (load_q8 <= lhb_pkg::load_out_t'(lhb_pkg::FULL_SCALE)))
		else $error("load above full scale");

endmodule
